[hw/rtl/psd_pkg.sv]
// ----------------------------------------------------------------------------
// psd_pkg: shared constants for the pump stall detector
// Window size, derived datapath widths, register indexes, reset values and
// command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

	// Sample window and the widths that follow from it.
	localparam int WINDOW  = 8;
	localparam int WIN_LOG = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int N2      = WINDOW * WINDOW;

	localparam int SMP_W  = 16;
	localparam int SUM_W  = SMP_W + WIN_LOG;
	localparam int SQ_W   = 2 * SMP_W + WIN_LOG;
	localparam int SV_W   = 2 * SMP_W + 2 * WIN_LOG;
	localparam int DUTY_W = 7;
	localparam int PROD_W = SV_W + DUTY_W;
	localparam int LVL_W  = 24;
	localparam int MUL_W  = SV_W + SUM_W;

	// Drive code divider widths: numerator and divisor stay below 100 * 2^16.
	localparam int CODE_W = 16;
	localparam int DEN_W  = 23;
	localparam int REM_W  = DEN_W + 1;

	// Step counter covers the window sweep and the divider steps.
	localparam int CNT_W = (WIN_LOG > 4) ? WIN_LOG : 4;

	localparam int DUTY_MAX = 100;
	localparam int TIME_W   = 32;
	localparam int STUP_W   = 16;
	localparam int RATED_W  = 16;

	// Input and output bus widths.
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 24;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCKED_LEVEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNBLOCKED_LEVEL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STARTUP_MS      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RATED_MV        = 3'd4;

	localparam logic [LVL_W-1:0]   RST_BLOCKED_LEVEL   = 24'd300000;
	localparam logic [LVL_W-1:0]   RST_UNBLOCKED_LEVEL = 24'd200000;
	localparam logic [STUP_W-1:0]  RST_STARTUP_MS      = 16'd200;
	localparam logic [DUTY_W-1:0]  RST_MIN_DUTY        = 7'd50;
	localparam logic [RATED_W-1:0] RST_RATED_MV        = 16'd12000;

	// Command codes carried in tuser.
	localparam logic CMD_SET    = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

endpackage

`default_nettype wire

[hw/rtl/pump_stall_detector_core.sv]
// ----------------------------------------------------------------------------
// pump_stall_detector_core: stall detection and drive compensation, one pump
// Keeps a ring of current samples, forms the scaled variance, judges the pump
// blocked with hysteresis and returns a battery compensated drive code.
// ----------------------------------------------------------------------------
//
//  channel   direction  content
//  s_*       in         tuser: cmd; tdata: duty, current, vbat, now
//  m_*       out        tdata: blocked, blocked_changed, drive_code
//  cfg_*     in         register writes, one per clock when cfg_we is high
//
// A set item is taken while the core is idle and gives no result.
// A sample item keeps s_tready low after its transfer while the sequencer
// sweeps the window on the shared multiplier and runs the 16-step restoring
// divider, which is skipped when the drive code saturates; no new item is
// taken until the result has been loaded into the output register.
// The result sits in an output register; a stalled m_tready holds only the
// final step, not the next item's acceptance once the register has drained.
// arst_n clears the sample ring, the flags, the duty and the start time.
`default_nettype none

module pump_stall_detector_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// tdata from bit 0: duty_percent[7:0], current_ma[15:0], vbat_mv[15:0], now_ms[31:0]
	input  wire logic [psd_pkg::IN_DATA_W-1:0]   s_tdata,
	// tuser: cmd
	input  wire logic                            s_tuser,
	// Output stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// tdata from bit 0: blocked, blocked_changed, drive_code[15:0], zero pad
	output logic [psd_pkg::OUT_DATA_W-1:0]       m_tdata,
	// Configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [psd_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  wire logic [psd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SUM  = 4'd1;
	localparam logic [3:0] S_SUM2 = 4'd2;
	localparam logic [3:0] S_VAR  = 4'd3;
	localparam logic [3:0] S_PROD = 4'd4;
	localparam logic [3:0] S_CMP  = 4'd5;
	localparam logic [3:0] S_DEN  = 4'd6;
	localparam logic [3:0] S_SAT  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;

	logic [3:0] state_q;

	// Configuration registers.
	logic [psd_pkg::LVL_W-1:0]   blk_lvl_q;
	logic [psd_pkg::LVL_W-1:0]   unb_lvl_q;
	logic [psd_pkg::STUP_W-1:0]  startup_q;
	logic [psd_pkg::DUTY_W-1:0]  min_duty_q;
	logic [psd_pkg::RATED_W-1:0] rated_q;

	// Pump state.
	logic [psd_pkg::SMP_W-1:0]   ring_q [psd_pkg::WINDOW];
	logic [psd_pkg::WIN_LOG-1:0] idx_q;
	logic [psd_pkg::DUTY_W-1:0]  duty_q;
	logic [psd_pkg::TIME_W-1:0]  start_q;
	logic                        blocked_q;
	logic                        chg_q;

	// Working registers of the sequencer.
	logic [psd_pkg::CNT_W-1:0]   cnt_q;
	logic [psd_pkg::SUM_W-1:0]   sum_q;
	logic [psd_pkg::SQ_W-1:0]    sumsq_q;
	logic [psd_pkg::SV_W-1:0]    svar_q;
	logic [psd_pkg::PROD_W-1:0]  mul_q;
	logic [psd_pkg::SMP_W-1:0]   vbat_q;
	logic                        started_q;
	logic [psd_pkg::REM_W-1:0]   rem_q;
	logic [psd_pkg::DEN_W-1:0]   den_q;
	logic [psd_pkg::CODE_W-1:0]  quo_q;

	// Output register.
	logic                            m_tvalid_q;
	logic [psd_pkg::OUT_DATA_W-1:0]  m_tdata_q;

	// Input field views.
	logic [7:0]                  in_duty;
	logic [psd_pkg::SMP_W-1:0]   in_cur;
	logic [psd_pkg::SMP_W-1:0]   in_vbat;
	logic [psd_pkg::TIME_W-1:0]  in_now;
	logic                        in_acc;
	logic [psd_pkg::DUTY_W-1:0]  duty_clamped;

	assign in_duty = s_tdata[7:0];
	assign in_cur  = s_tdata[23:8];
	assign in_vbat = s_tdata[39:24];
	assign in_now  = s_tdata[71:40];
	assign in_acc  = s_tvalid && s_tready;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Clamp the requested duty to 0..100; negative requests mean off.
	always_comb begin
		if (in_duty[7]) begin
			duty_clamped = '0;
		end else if (in_duty > 8'(psd_pkg::DUTY_MAX)) begin
			duty_clamped = psd_pkg::DUTY_W'(psd_pkg::DUTY_MAX);
		end else begin
			duty_clamped = in_duty[psd_pkg::DUTY_W-1:0];
		end
	end

	// Shared multiplier: operands chosen by the sequencer state.
	logic [psd_pkg::SV_W-1:0]  mul_a;
	logic [psd_pkg::SUM_W-1:0] mul_b;
	logic [psd_pkg::MUL_W-1:0] mul_full;
	logic [psd_pkg::SMP_W-1:0] ring_rd;

	assign ring_rd = ring_q[cnt_q[psd_pkg::WIN_LOG-1:0]];

	always_comb begin
		case (state_q)
			S_SUM: begin
				mul_a = psd_pkg::SV_W'(ring_rd);
				mul_b = psd_pkg::SUM_W'(ring_rd);
			end
			S_SUM2: begin
				mul_a = psd_pkg::SV_W'(sum_q);
				mul_b = sum_q;
			end
			S_PROD: begin
				mul_a = svar_q;
				mul_b = psd_pkg::SUM_W'(duty_q);
			end
			S_CMP: begin
				mul_a = psd_pkg::SV_W'(duty_q);
				mul_b = psd_pkg::SUM_W'(rated_q);
			end
			S_DEN: begin
				mul_a = psd_pkg::SV_W'(vbat_q);
				mul_b = psd_pkg::SUM_W'(psd_pkg::DUTY_MAX);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// Scaled variance, forced to zero below the minimum duty.
	logic [psd_pkg::SV_W-1:0] svar_nxt;

	always_comb begin
		if (duty_q < min_duty_q) begin
			svar_nxt = '0;
		end else begin
			svar_nxt = psd_pkg::SV_W'(psd_pkg::SV_W'(sumsq_q) * psd_pkg::SV_W'(psd_pkg::WINDOW))
				- mul_q[psd_pkg::SV_W-1:0];
		end
	end

	// Hysteresis decision on variance times duty.
	logic [psd_pkg::PROD_W-1:0] blk_lim;
	logic [psd_pkg::PROD_W-1:0] unb_lim;
	logic                       blocked_nxt;

	assign blk_lim = psd_pkg::PROD_W'(psd_pkg::PROD_W'(blk_lvl_q) * psd_pkg::PROD_W'(psd_pkg::N2));
	assign unb_lim = psd_pkg::PROD_W'(psd_pkg::PROD_W'(unb_lvl_q) * psd_pkg::PROD_W'(psd_pkg::N2));

	always_comb begin
		if (started_q && (mul_q > blk_lim)) begin
			blocked_nxt = 1'b1;
		end else if (mul_q < unb_lim) begin
			blocked_nxt = 1'b0;
		end else begin
			blocked_nxt = blocked_q;
		end
	end

	// One restoring division step.
	logic [psd_pkg::REM_W-1:0] rem_sh;
	logic                      div_ge;

	assign rem_sh = {rem_q[psd_pkg::REM_W-2:0], 1'b0};
	assign div_ge = (rem_sh >= psd_pkg::REM_W'(den_q));

	// Multiplier output register.
	always_ff @(posedge clk) begin
		mul_q <= psd_pkg::PROD_W'(mul_full);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_lvl_q  <= psd_pkg::RST_BLOCKED_LEVEL;
			unb_lvl_q  <= psd_pkg::RST_UNBLOCKED_LEVEL;
			startup_q  <= psd_pkg::RST_STARTUP_MS;
			min_duty_q <= psd_pkg::RST_MIN_DUTY;
			rated_q    <= psd_pkg::RST_RATED_MV;
		end else if (cfg_we) begin
			case (cfg_idx)
				psd_pkg::REG_BLOCKED_LEVEL:   blk_lvl_q  <= cfg_data;
				psd_pkg::REG_UNBLOCKED_LEVEL: unb_lvl_q  <= cfg_data;
				psd_pkg::REG_STARTUP_MS:      startup_q  <= cfg_data[psd_pkg::STUP_W-1:0];
				psd_pkg::REG_MIN_DUTY:        min_duty_q <= cfg_data[psd_pkg::DUTY_W-1:0];
				psd_pkg::REG_RATED_MV:        rated_q    <= cfg_data[psd_pkg::RATED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sample ring, written once per accepted sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psd_pkg::WINDOW; i++) begin
				ring_q[i] <= '0;
			end
			idx_q <= '0;
		end else if (in_acc && (s_tuser == psd_pkg::CMD_SAMPLE)) begin
			ring_q[idx_q] <= in_cur;
			if (idx_q == psd_pkg::WIN_LOG'(psd_pkg::WINDOW - 1)) begin
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Duty and start time, updated by set items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q  <= '0;
			start_q <= '0;
		end else if (in_acc && (s_tuser == psd_pkg::CMD_SET)) begin
			if ((duty_clamped != '0) && (duty_q == '0)) begin
				start_q <= in_now;
			end
			duty_q <= duty_clamped;
		end
	end

	// Sequencer and its working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			blocked_q <= 1'b0;
			chg_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && (s_tuser == psd_pkg::CMD_SAMPLE)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					if (cnt_q == psd_pkg::CNT_W'(psd_pkg::WINDOW - 1)) begin
						state_q <= S_SUM2;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_SUM2: state_q <= S_VAR;
				S_VAR:  state_q <= S_PROD;
				S_PROD: state_q <= S_CMP;
				S_CMP: begin
					chg_q     <= (blocked_nxt != blocked_q);
					blocked_q <= blocked_nxt;
					state_q   <= S_DEN;
				end
				S_DEN: state_q <= S_SAT;
				S_SAT: begin
					cnt_q <= '0;
					if (rem_q >= psd_pkg::REM_W'(mul_q)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == psd_pkg::CNT_W'(psd_pkg::CODE_W - 1)) begin
						state_q <= S_OUT;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (in_acc) begin
				cnt_q <= '0;
			end
		end
	end

	// Datapath registers loaded by the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				sum_q     <= '0;
				sumsq_q   <= '0;
				vbat_q    <= in_vbat;
				started_q <= ((in_now - start_q) > psd_pkg::TIME_W'(startup_q));
			end
			S_SUM: begin
				sum_q <= sum_q + psd_pkg::SUM_W'(ring_rd);
				if (cnt_q != '0) begin
					sumsq_q <= sumsq_q + mul_q[psd_pkg::SQ_W-1:0];
				end
			end
			S_SUM2: sumsq_q <= sumsq_q + mul_q[psd_pkg::SQ_W-1:0];
			S_VAR:  svar_q  <= svar_nxt;
			S_DEN:  rem_q   <= mul_q[psd_pkg::REM_W-1:0];
			S_SAT: begin
				den_q <= mul_q[psd_pkg::DEN_W-1:0];
				// A quotient that would not fit in 16 bits saturates to all ones.
				quo_q <= (rem_q >= psd_pkg::REM_W'(mul_q)) ? '1 : '0;
			end
			S_DIV: begin
				rem_q <= div_ge ? (rem_sh - psd_pkg::REM_W'(den_q)) : rem_sh;
				quo_q <= {quo_q[psd_pkg::CODE_W-2:0], div_ge};
			end
			default: begin
			end
		endcase
	end

	// Output register: loads when empty or when the current result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == S_OUT) && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= psd_pkg::OUT_DATA_W'({quo_q, chg_q, blocked_q});
		end
	end

`ifndef SYNTHESIS
	// A new result appears only from the final sequencer step.
	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT))
		else $error("result presented outside the output step");

	// The divider remainder stays below the divisor on every step.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (rem_q < psd_pkg::REM_W'(den_q)))
		else $error("divider remainder out of range");

	// The blocked flag changes only at the decision step.
	a_blk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_CMP) |=> $stable(blocked_q))
		else $error("blocked flag changed outside the decision step");

	// The ring index advances only with an accepted sample.
	a_idx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && (s_tuser == psd_pkg::CMD_SAMPLE)) |=> $stable(idx_q))
		else $error("ring index moved without a sample transfer");
`endif

endmodule

`default_nettype wire

[verif/psd_checker.sv]
// ----------------------------------------------------------------------------
// psd_checker: result predictor and scoreboard for the pump stall detector
// Watches the input, output and register write channels of the core. Each
// accepted command runs through a local model of the duty, the sample window
// and the blocked hysteresis, and each status transfer is compared with the
// oldest predicted status.
// ----------------------------------------------------------------------------

module psd_checker import psd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// tdata from bit 0: duty_percent[7:0], current_ma[15:0], vbat_mv[15:0], now_ms[31:0]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// tuser: cmd
	input  logic                  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// tdata from bit 0: blocked, blocked_changed, drive_code[15:0], zero pad
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding
);

	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [15:0]       vbat_mv;
		logic [SMP_W-1:0]  current_ma;
		logic [7:0]        duty_raw;
	} pump_cmd_t;

	typedef struct packed {
		logic [OUT_DATA_W-CODE_W-3:0] pad;
		logic [CODE_W-1:0]            drive_code;
		logic                         changed;
		logic                         blocked;
	} pump_status_t;

	// Register copies.
	logic [LVL_W-1:0]   lvl_block;
	logic [LVL_W-1:0]   lvl_clear;
	logic [STUP_W-1:0]  settle_ms;
	logic [DUTY_W-1:0]  duty_floor;
	logic [RATED_W-1:0] rated_mv;

	// Pump state.
	logic [SMP_W-1:0]   window_ring [WINDOW];
	int                 ring_slot;
	logic [DUTY_W-1:0]  duty_pct;
	logic [TIME_W-1:0]  start_ms;
	logic               is_blocked;

	pump_status_t status_due [$];
	pump_status_t got, want;
	int           n_bad;

	task automatic note_failure(input string msg);
		n_bad++;
		if (n_bad <= REPORT_MAX) begin
			$display("%s", msg);
		end
	endtask

	// Apply one command to the model and queue the status that a sample produces.
	task automatic absorb_command(input logic cmd, input pump_cmd_t c);
		logic [DUTY_W-1:0] d;
		bit [63:0]         total, total_sq, spread, load, num, code;
		bit [TIME_W-1:0]   elapsed;
		logic              was_blocked;
		pump_status_t      st;
		if (cmd == CMD_SET) begin
			// Negative requests turn the pump off, large ones are clamped.
			if (c.duty_raw[7]) begin
				d = '0;
			end else if (c.duty_raw > DUTY_MAX) begin
				d = DUTY_W'(DUTY_MAX);
			end else begin
				d = c.duty_raw[DUTY_W-1:0];
			end
			if (d != 0 && duty_pct == 0) begin
				start_ms = c.now_ms;
			end
			duty_pct = d;
		end else begin
			was_blocked = is_blocked;
			window_ring[ring_slot] = c.current_ma;
			ring_slot = (ring_slot + 1) % WINDOW;

			// Scaled variance over the window, zero below the duty floor.
			total = 0;
			total_sq = 0;
			for (int i = 0; i < WINDOW; i++) begin
				total += 64'(window_ring[i]);
				total_sq += 64'(window_ring[i]) * 64'(window_ring[i]);
			end
			spread = 64'(WINDOW) * total_sq - total * total;
			if (duty_pct < duty_floor) begin
				spread = 0;
			end
			load = spread * 64'(duty_pct);
			elapsed = c.now_ms - start_ms;

			// Hysteresis; the flag holds when neither bound is crossed.
			if (elapsed > settle_ms && load > 64'(lvl_block) * 64'(N2)) begin
				is_blocked = 1'b1;
			end else if (load < 64'(lvl_clear) * 64'(N2)) begin
				is_blocked = 1'b0;
			end

			// Battery compensated drive code, saturated.
			if (c.vbat_mv == 0) begin
				code = 64'({CODE_W{1'b1}});
			end else begin
				num = (64'(duty_pct) * 64'(rated_mv)) << 16;
				code = num / (64'(c.vbat_mv) * 64'(DUTY_MAX));
				if (code > 64'({CODE_W{1'b1}})) begin
					code = 64'({CODE_W{1'b1}});
				end
			end

			st = '0;
			st.blocked = is_blocked;
			st.changed = is_blocked != was_blocked;
			st.drive_code = code[CODE_W-1:0];
			status_due.push_back(st);
		end
	endtask

	// Model update and comparison on every transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_block = RST_BLOCKED_LEVEL;
			lvl_clear = RST_UNBLOCKED_LEVEL;
			settle_ms = RST_STARTUP_MS;
			duty_floor = RST_MIN_DUTY;
			rated_mv = RST_RATED_MV;
			for (int i = 0; i < WINDOW; i++) begin
				window_ring[i] = '0;
			end
			ring_slot = 0;
			duty_pct = '0;
			start_ms = '0;
			is_blocked = 1'b0;
			status_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_BLOCKED_LEVEL:   lvl_block = cfg_data[LVL_W-1:0];
					REG_UNBLOCKED_LEVEL: lvl_clear = cfg_data[LVL_W-1:0];
					REG_STARTUP_MS:      settle_ms = cfg_data[STUP_W-1:0];
					REG_MIN_DUTY:        duty_floor = cfg_data[DUTY_W-1:0];
					REG_RATED_MV:        rated_mv = cfg_data[RATED_W-1:0];
					default: ;
				endcase
			end

			// Results leave before this edge's command is predicted.
			if (m_tvalid && m_tready) begin
				got = pump_status_t'(m_tdata);
				if (status_due.size() == 0) begin
					note_failure($sformatf("unexpected status transfer: blocked=%0d changed=%0d code=%0d",
						got.blocked, got.changed, got.drive_code));
				end else begin
					want = status_due.pop_front();
					if (got.blocked !== want.blocked || got.changed !== want.changed ||
							got.drive_code !== want.drive_code) begin
						note_failure($sformatf(
							"status mismatch: expected blocked=%0d changed=%0d code=%0d, got blocked=%0d changed=%0d code=%0d",
							want.blocked, want.changed, want.drive_code,
							got.blocked, got.changed, got.drive_code));
					end
				end
			end

			if (s_tvalid && s_tready) begin
				absorb_command(s_tuser, pump_cmd_t'(s_tdata));
			end
			outstanding <= status_due.size();
		end
	end

	initial begin
		n_bad = 0;
	end

	always @(posedge clk) begin
		fail_count <= n_bad;
	end

endmodule

[verif/tb_pump_stall_detector_core.sv]
// ----------------------------------------------------------------------------
// tb_pump_stall_detector_core: stimulus and verdict for the stall detector
// Runs a directed opening on duty clamping, time wrap, zero battery voltage
// and the blocked hysteresis, then random duty and sample sequences under
// several register settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module tb_pump_stall_detector_core;
	import psd_pkg::*;

	localparam int STALL_LIMIT   = 3000;
	localparam int HOLDOFF_LEN   = 400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASE_ITEMS   = 330;
	localparam int PHASE_COUNT   = 6;

	// Register index that the core does not implement.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// tdata from bit 0: duty_percent[7:0], current_ma[15:0], vbat_mv[15:0], now_ms[31:0]
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// tuser: cmd
	logic                  s_tuser = CMD_SET;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// tdata from bit 0: blocked, blocked_changed, drive_code[15:0], zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int   fail_count;
	int   outstanding;
	int   items_sent = 0;
	int   burst_left = 0;
	bit   holdoff_req = 1'b0;
	logic [TIME_W-1:0] clock_ms = '0;

	always #4 clk = ~clk;

	pump_stall_detector_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	psd_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	// Offer one command and wait for its transfer; bursts end in random gaps.
	task automatic send_item(input logic cmd, input logic [7:0] duty, input logic [15:0] cur,
			input logic [15:0] vbat, input logic [TIME_W-1:0] now);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {now, vbat, cur, duty};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait until every status has come back.
	task automatic settle_block();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [LVL_W-1:0] bl, input logic [LVL_W-1:0] ubl,
			input logic [STUP_W-1:0] stup, input logic [DUTY_W-1:0] mind,
			input logic [RATED_W-1:0] rated, input bit poke_unused);
		write_reg(REG_BLOCKED_LEVEL, bl);
		write_reg(REG_UNBLOCKED_LEVEL, ubl);
		write_reg(REG_STARTUP_MS, stup);
		write_reg(REG_MIN_DUTY, mind);
		write_reg(REG_RATED_MV, rated);
		if (poke_unused) begin
			write_reg(REG_UNUSED, $urandom_range(0, 16777215));
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] pick_vbat();
		int r;
		r = $urandom_range(0, 15);
		case (r)
			0: return 16'd0;
			1: return $urandom_range(1, 3000);
			2: return $urandom_range(0, 65535);
			default: return $urandom_range(9000, 16000);
		endcase
	endfunction

	// Mostly in range, sometimes above 100 or negative.
	function automatic logic [7:0] pick_duty();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return $urandom_range(101, 127);
			1: return $urandom_range(128, 255);
			default: return $urandom_range(1, 100);
		endcase
	endfunction

	// System time moves forward in small steps, with rare jumps and wraps.
	function automatic logic [TIME_W-1:0] tick_clock();
		int r;
		r = $urandom_range(0, 63);
		if (r == 0) begin
			clock_ms = $urandom();
		end else if (r == 1) begin
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
		end else begin
			clock_ms = clock_ms + $urandom_range(0, 25);
		end
		return clock_ms;
	endfunction

	// A duty change followed by a run of samples with a chosen noise level.
	task automatic run_pump_episode();
		int n, base, amp, v, pick;
		if ($urandom_range(0, 2) == 0) begin
			send_item(CMD_SET, ($urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(128, 255))),
				$urandom_range(0, 65535), $urandom_range(0, 65535), tick_clock());
		end
		send_item(CMD_SET, pick_duty(), $urandom_range(0, 65535), $urandom_range(0, 65535),
			tick_clock());
		n = $urandom_range(8, 40);
		base = $urandom_range(0, 65535);
		pick = $urandom_range(0, 5);
		case (pick)
			0: amp = 0;
			1: amp = 8;
			2: amp = 60;
			3: amp = 400;
			4: amp = 4000;
			default: amp = 65535;
		endcase
		repeat (n) begin
			v = base + $urandom_range(0, 2 * amp) - amp;
			if (v < 0) v = 0;
			if (v > 65535) v = 65535;
			send_item(CMD_SAMPLE, $urandom_range(0, 255), v, pick_vbat(), tick_clock());
		end
	endtask

	task automatic run_noise();
		repeat ($urandom_range(1, 6)) begin
			send_item($urandom_range(0, 1), $urandom_range(0, 255), $urandom_range(0, 65535),
				$urandom_range(0, 65535), $urandom());
		end
	endtask

	task automatic run_random_phase(input int n_items);
		int goal;
		goal = items_sent + n_items;
		while (items_sent < goal) begin
			if ($urandom_range(0, 9) < 8) begin
				run_pump_episode();
			end else begin
				run_noise();
			end
		end
	endtask

	// Receiver: segments of steady, random or sparse acceptance, plus hold-offs.
	initial begin : receiver
		int seg_left, mode;
		seg_left = 0;
		mode = 0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				holdoff_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLDOFF_LEN) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					mode = $urandom_range(0, 3);
					seg_left = $urandom_range(5, 60);
				end
				seg_left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Watchdog on cycles without any transfer.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_pump_stall_detector_core NOT OK");
		$finish;
	end

	initial begin : stimulus
		logic [LVL_W-1:0] bl;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed opening at the reset settings.
		send_item(CMD_SAMPLE, 8'd0, 16'd0, 16'd0, 32'd0);
		send_item(CMD_SET, 8'h80, 16'hFFFF, 16'hFFFF, 32'd5);
		send_item(CMD_SET, 8'h7F, 16'd0, 16'd0, 32'hFFFF_FF00);
		send_item(CMD_SAMPLE, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FF10);
		send_item(CMD_SAMPLE, 8'h00, 16'd0, 16'd1, 32'hFFFF_FF20);
		send_item(CMD_SAMPLE, 8'h00, 16'hFFFF, 16'd12000, 32'h0000_0100);
		send_item(CMD_SAMPLE, 8'h00, 16'd0, 16'd0, 32'h0000_0110);
		send_item(CMD_SET, 8'hFF, 16'd0, 16'd0, 32'h0000_0120);
		send_item(CMD_SAMPLE, 8'h00, 16'd0, 16'd12000, 32'h0000_0130);
		send_item(CMD_SET, 8'd49, 16'd0, 16'd0, 32'h0000_0140);
		send_item(CMD_SAMPLE, 8'h00, 16'hFFFF, 16'd12000, 32'h0000_0150);
		send_item(CMD_SET, 8'd50, 16'd0, 16'd0, 32'h0000_0160);
		for (int i = 0; i < 4; i++) begin
			send_item(CMD_SAMPLE, 8'h00, (i % 2) ? 16'd0 : 16'hFFFF, 16'd12000,
				32'h0000_0400 + i);
		end
		send_item(CMD_SET, 8'd100, 16'd0, 16'd0, 32'h0000_0500);
		send_item(CMD_SET, 8'd101, 16'd0, 16'd0, 32'h0000_0510);
		for (int i = 0; i < 6; i++) begin
			send_item(CMD_SAMPLE, 8'h00, 16'd1000, 16'd24000, 32'h0000_0600 + i);
		end
		clock_ms = 32'h0000_1000;

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle_block();
			case (p)
				0: apply_settings(RST_BLOCKED_LEVEL, RST_UNBLOCKED_LEVEL, RST_STARTUP_MS,
					RST_MIN_DUTY, RST_RATED_MV, 1'b0);
				1: apply_settings(24'd0, 24'd0, 16'd0, 7'd0, 16'hFFFF, 1'b0);
				2: apply_settings(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 7'd100, 16'd0, 1'b0);
				3: begin
					bl = $urandom_range(0, 2000000);
					apply_settings(bl, $urandom_range(0, bl), $urandom_range(0, 300),
						$urandom_range(0, 100), $urandom_range(0, 65535), 1'b1);
				end
				4: begin
					bl = $urandom_range(1000, 400000);
					apply_settings(bl, $urandom_range(0, bl), $urandom_range(0, 60),
						$urandom_range(20, 80), $urandom_range(3000, 30000), 1'b0);
				end
				default: apply_settings($urandom_range(0, 16777215), $urandom_range(0, 16777215),
					$urandom_range(0, 500), $urandom_range(0, 100), $urandom_range(0, 65535), 1'b0);
			endcase
			// The receiver holds off at the start of the first phase so the core backs up.
			if (p == 0) begin
				holdoff_req = 1'b1;
			end
			run_random_phase(PHASE_ITEMS);
		end

		settle_block();
		if (fail_count == 0) begin
			$display("tb_pump_stall_detector_core OK");
		end else begin
			$display("tb_pump_stall_detector_core NOT OK");
		end
		$finish;
	end

endmodule
